/* rtl/cyrillic_translit_name_filter_assert.svh */
// ---------------------------------------------------------------------------
// assertion macros for the name filter
// concurrent checks that compile away when NO_ASSERTIONS is set
// ---------------------------------------------------------------------------
`ifndef CYRILLIC_TRANSLIT_NAME_FILTER_ASSERT_SVH
`define CYRILLIC_TRANSLIT_NAME_FILTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define CTNF_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("name filter check failed");

`define CTNF_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("name filter check failed");

`define CTNF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("name filter check failed");

`else

`define CTNF_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define CTNF_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define CTNF_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/ctnf_pkg.sv */
// ---------------------------------------------------------------------------
// ctnf_pkg
// types, codes and the cyrillic letter table of the name filter
// ---------------------------------------------------------------------------
package ctnf_pkg;

   // status on the end beat
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_IN_LONG = 2'd1;
   localparam logic [1:0] ST_TRUNC   = 2'd2;

   // byte classes
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_LEAD   = 2'd1;
   localparam logic [1:0] KIND_USCORE = 2'd2;
   localparam logic [1:0] KIND_CHARS  = 2'd3;

   localparam logic [7:0] LEAD_D0    = 8'hD0;
   localparam logic [7:0] LEAD_D1    = 8'hD1;
   localparam logic [7:0] CHAR_USC   = 8'h5F;
   localparam logic [8:0] MAX_IN     = 9'd255;
   localparam logic [8:0] IN_SAT     = 9'd511;
   localparam int         UNIT_SLOTS = 6;

   // chars[3] is the first letter
   typedef struct packed {
      logic [2:0]      nchar;
      logic [3:0][7:0] chars;
   } letters_type;

   typedef struct packed {
      logic [1:0]      kind;
      logic [2:0]      nchar;
      logic [3:0][7:0] chars;
   } class_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_end;
      logic [1:0] status;
   } slot_type;

   typedef struct packed {
      logic [2:0]                       cnt;
      slot_type [UNIT_SLOTS-1:0]        slots;
   } unit_type;

   function automatic letters_type lt(input logic [2:0] n, input logic [31:0] c);
      letters_type r;
      r.nchar = n;
      r.chars = c;
      return r;
   endfunction

   // alphabet order, yo last
   function automatic letters_type cyr_letters(input logic [5:0] idx);
      letters_type r;
      case (idx)
         6'd0:  r = lt(3'd1, {"a", 24'h0});
         6'd1:  r = lt(3'd1, {"b", 24'h0});
         6'd2:  r = lt(3'd1, {"v", 24'h0});
         6'd3:  r = lt(3'd1, {"g", 24'h0});
         6'd4:  r = lt(3'd1, {"d", 24'h0});
         6'd5:  r = lt(3'd1, {"e", 24'h0});
         6'd6:  r = lt(3'd2, {"zh", 16'h0});
         6'd7:  r = lt(3'd1, {"z", 24'h0});
         6'd8:  r = lt(3'd1, {"i", 24'h0});
         6'd9:  r = lt(3'd1, {"j", 24'h0});
         6'd10: r = lt(3'd1, {"k", 24'h0});
         6'd11: r = lt(3'd1, {"l", 24'h0});
         6'd12: r = lt(3'd1, {"m", 24'h0});
         6'd13: r = lt(3'd1, {"n", 24'h0});
         6'd14: r = lt(3'd1, {"o", 24'h0});
         6'd15: r = lt(3'd1, {"p", 24'h0});
         6'd16: r = lt(3'd1, {"r", 24'h0});
         6'd17: r = lt(3'd1, {"s", 24'h0});
         6'd18: r = lt(3'd1, {"t", 24'h0});
         6'd19: r = lt(3'd1, {"u", 24'h0});
         6'd20: r = lt(3'd1, {"f", 24'h0});
         6'd21: r = lt(3'd1, {"h", 24'h0});
         6'd22: r = lt(3'd1, {"c", 24'h0});
         6'd23: r = lt(3'd2, {"ch", 16'h0});
         6'd24: r = lt(3'd2, {"sh", 16'h0});
         6'd25: r = lt(3'd4, "shch");
         6'd26: r = lt(3'd0, 32'h0);
         6'd27: r = lt(3'd1, {"y", 24'h0});
         6'd28: r = lt(3'd0, 32'h0);
         6'd29: r = lt(3'd1, {"e", 24'h0});
         6'd30: r = lt(3'd2, {"iu", 16'h0});
         6'd31: r = lt(3'd2, {"ia", 16'h0});
         6'd32: r = lt(3'd2, {"io", 16'h0});
         default: r = lt(3'd0, 32'h0);
      endcase
      return r;
   endfunction

   // unknown pairs give no letters
   function automatic letters_type cyr_pair(input logic d1, input logic [7:0] b);
      letters_type r;
      r = lt(3'd0, 32'h0);
      if (!d1) begin
         if (b inside {[8'h90:8'hAF]}) r = cyr_letters({1'b0, 5'(b - 8'h90)});
         else if (b inside {[8'hB0:8'hBF]}) r = cyr_letters({2'b00, 4'(b - 8'hB0)});
         else if (b inside {8'h01, 8'h81}) r = cyr_letters(6'd32);
      end else begin
         if (b inside {[8'h80:8'h8F]}) r = cyr_letters({2'b01, 4'(b - 8'h80)});
         else if (b == 8'h91) r = cyr_letters(6'd32);
      end
      return r;
   endfunction

endpackage

/* rtl/ctnf_if.sv */
// ---------------------------------------------------------------------------
// ctnf channel interfaces
// valid/ready channels for string bytes in and characters out
// ---------------------------------------------------------------------------
interface ctnf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       is_last;

   modport source (output valid, output in_byte, output is_last, input ready);
   modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface ctnf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_end;
   logic [1:0] status;

   modport source (output valid, output out_byte, output is_end, output status,
                   input ready);
   modport sink   (input valid, input out_byte, input is_end, input status,
                   output ready);
endinterface

/* rtl/cyrillic_translit_name_filter.sv */
// path: an accepted byte goes through the input register, then the beat buffer, to the result port
// throughput: one byte per cycle while the result port is ready and each byte
//   gives at most one beat; else the input waits for the last beat to go out
// reset: synchronous, active high; clears all string state and empties both
//   the input register and the beat buffer
// ---------------------------------------------------------------------------
// cyrillic_translit_name_filter
// utf-8 to lowercase latin file-name filter with output length cap
// ---------------------------------------------------------------------------
`include "cyrillic_translit_name_filter_assert.svh"

module cyrillic_translit_name_filter
   import ctnf_pkg::*;
#(
   parameter int MAX_LEN = 255
)(
   input  logic       clock,
   input  logic       reset,
   ctnf_req_if.sink   req_ch,
   ctnf_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(MAX_LEN);
   localparam logic [CNT_W:0] MAX_LEN_V = (CNT_W+1)'(MAX_LEN);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_last_ff, in_last_in;

   // string state
   logic             lead_pending_ff, lead_pending_in;
   logic             lead_is_d1_ff, lead_is_d1_in;
   logic             us_pending_ff, us_pending_in;
   logic [CNT_W-1:0] out_count_ff, out_count_in;
   logic [8:0]       in_count_ff, in_count_in;
   logic             truncated_ff, truncated_in;

   class_type  cls;
   unit_type   unit;
   logic       ser_free;
   logic       move;
   logic       has_chars;
   logic       over;
   logic       emit_ok;
   logic [2:0] total;
   logic [2:0] nemit;
   logic [CNT_W:0] sum;
   logic [4:0][7:0] seq;
   logic [1:0] end_status;

   ctnf_classify u_classify (
      .in_byte      (in_byte_ff),
      .lead_pending (lead_pending_ff),
      .lead_is_d1   (lead_is_d1_ff),
      .cls          (cls)
   );

   assign move         = in_valid_ff && ser_free;
   assign req_ch.ready = !in_valid_ff || move;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_ch.in_byte;
         in_last_in  = req_ch.is_last;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
   end

   // a letter group and an owed underscore go out together or not at all
   always_comb begin
      has_chars = (cls.kind == KIND_CHARS) && (cls.nchar != 3'd0) && !truncated_ff;
      total     = cls.nchar + {2'b00, us_pending_ff};
      sum       = {1'b0, out_count_ff} + (CNT_W+1)'(total);
      over      = (sum >= MAX_LEN_V);
      emit_ok   = has_chars && !over;
      nemit     = emit_ok ? total : 3'd0;
      seq[0]    = us_pending_ff ? CHAR_USC : cls.chars[3];
      for (int i = 1; i < 4; i++) begin
         seq[i] = us_pending_ff ? cls.chars[4-i] : cls.chars[3-i];
      end
      seq[4] = us_pending_ff ? cls.chars[0] : 8'h00;
   end

   always_comb begin
      in_count_in     = (in_count_ff == IN_SAT) ? in_count_ff : in_count_ff + 9'd1;
      lead_pending_in = lead_pending_ff;
      lead_is_d1_in   = lead_is_d1_ff;
      us_pending_in   = us_pending_ff;
      out_count_in    = out_count_ff;
      truncated_in    = truncated_ff || (has_chars && over);
      if (lead_pending_ff) begin
         lead_pending_in = 1'b0;
      end else if (cls.kind == KIND_LEAD) begin
         lead_pending_in = 1'b1;
         lead_is_d1_in   = (in_byte_ff == LEAD_D1);
      end
      if (cls.kind == KIND_USCORE) begin
         us_pending_in = 1'b1;
      end
      if (emit_ok) begin
         us_pending_in = 1'b0;
         out_count_in  = sum[CNT_W-1:0];
      end

      if (in_count_in > MAX_IN) end_status = ST_IN_LONG;
      else if (truncated_in) end_status = ST_TRUNC;
      else end_status = ST_OK;

      if (in_last_ff) begin
         lead_pending_in = 1'b0;
         lead_is_d1_in   = 1'b0;
         us_pending_in   = 1'b0;
         out_count_in    = '0;
         in_count_in     = 9'd0;
         truncated_in    = 1'b0;
      end
   end

   // unit: emitted characters, then the end beat when the byte is the last
   always_comb begin
      unit.cnt = nemit + {2'b00, in_last_ff};
      for (int p = 0; p < UNIT_SLOTS; p++) begin
         if (p < 5 && 3'(p) < nemit) begin
            unit.slots[p].out_byte = seq[p];
            unit.slots[p].is_end   = 1'b0;
            unit.slots[p].status   = ST_OK;
         end else begin
            unit.slots[p].out_byte = 8'h00;
            unit.slots[p].is_end   = 1'b1;
            unit.slots[p].status   = end_status;
         end
      end
   end

   ctnf_serializer u_serializer (
      .clock  (clock),
      .reset  (reset),
      .load   (move),
      .unit   (unit),
      .free   (ser_free),
      .rsp_ch (rsp_ch)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         lead_pending_ff <= 1'b0;
         lead_is_d1_ff   <= 1'b0;
         us_pending_ff   <= 1'b0;
         out_count_ff    <= '0;
         in_count_ff     <= 9'd0;
         truncated_ff    <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (move) begin
            lead_pending_ff <= lead_pending_in;
            lead_is_d1_ff   <= lead_is_d1_in;
            us_pending_ff   <= us_pending_in;
            out_count_ff    <= out_count_in;
            in_count_ff     <= in_count_in;
            truncated_ff    <= truncated_in;
         end
      end
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
   end

   `CTNF_ASSERT_ALWAYS(a_count_below_cap, clock, reset,
                       {1'b0, out_count_ff} < MAX_LEN_V)
   `CTNF_ASSERT_NEXT(a_pair_consumed, clock, reset, move && lead_pending_ff,
                     !lead_pending_ff)
   `CTNF_ASSERT_NEXT(a_clear_at_end, clock, reset, move && in_last_ff,
                     out_count_ff == '0 && !truncated_ff && in_count_ff == 9'd0)
   `CTNF_ASSERT_NEXT(a_hold_when_stalled, clock, reset, in_valid_ff && !move,
                     in_valid_ff && $stable(in_byte_ff))

endmodule

/* rtl/ctnf_classify.sv */
// ---------------------------------------------------------------------------
// ctnf_classify
// sorts one byte into lead, underscore or a group of output letters
// ---------------------------------------------------------------------------
module ctnf_classify
   import ctnf_pkg::*;
(
   input  logic [7:0] in_byte,
   input  logic       lead_pending,
   input  logic       lead_is_d1,
   output class_type  cls
);

   letters_type pair;

   always_comb begin
      pair = cyr_pair(lead_is_d1, in_byte);
      cls.kind  = KIND_NONE;
      cls.nchar = 3'd0;
      cls.chars = '0;
      if (lead_pending) begin
         cls.kind  = KIND_CHARS;
         cls.nchar = pair.nchar;
         cls.chars = pair.chars;
      end else if (in_byte == LEAD_D0 || in_byte == LEAD_D1) begin
         cls.kind = KIND_LEAD;
      end else if (in_byte inside {[8'h30:8'h39], [8'h61:8'h7A], 8'h2E}) begin
         cls.kind     = KIND_CHARS;
         cls.nchar    = 3'd1;
         cls.chars[3] = in_byte;
      end else if (in_byte inside {[8'h41:8'h5A]}) begin
         cls.kind     = KIND_CHARS;
         cls.nchar    = 3'd1;
         cls.chars[3] = in_byte + 8'd32;
      end else begin
         cls.kind = KIND_USCORE;
      end
   end

endmodule

/* rtl/ctnf_serializer.sv */
// ---------------------------------------------------------------------------
// ctnf_serializer
// holds one unit of up to six result beats and sends them one per cycle while the result port is ready
// ---------------------------------------------------------------------------
`include "cyrillic_translit_name_filter_assert.svh"

module ctnf_serializer
   import ctnf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  unit_type    unit,
   output logic        free,
   ctnf_rsp_if.source  rsp_ch
);

   logic [2:0]                cnt_ff, cnt_in;
   slot_type [UNIT_SLOTS-1:0] slots_ff, slots_in;
   logic                      take;

   assign take = rsp_ch.valid && rsp_ch.ready;
   assign free = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && take);

   assign rsp_ch.valid    = (cnt_ff != 3'd0);
   assign rsp_ch.out_byte = slots_ff[0].out_byte;
   assign rsp_ch.is_end   = slots_ff[0].is_end;
   assign rsp_ch.status   = slots_ff[0].status;

   always_comb begin
      cnt_in   = cnt_ff;
      slots_in = slots_ff;
      if (load) begin
         cnt_in   = unit.cnt;
         slots_in = unit.slots;
      end else if (take) begin
         cnt_in = cnt_ff - 3'd1;
         for (int i = 0; i < UNIT_SLOTS - 1; i++) begin
            slots_in[i] = slots_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slots_ff <= slots_in;
   end

   `CTNF_ASSERT_ALWAYS(a_cnt_range, clock, reset, cnt_ff <= 3'(UNIT_SLOTS))
   `CTNF_ASSERT_SAME(a_load_when_free, clock, reset, load, free)
   `CTNF_ASSERT_NEXT(a_drain_step, clock, reset, cnt_ff > 3'd1 && take,
                     cnt_ff == $past(cnt_ff) - 3'd1)

endmodule
